// ===== rtl/clu_pkg.sv =====
// Shared types, codes and constants of the load instruction unit.
`timescale 1ns / 1ps

package clu_pkg;

  // Main memory geometry, fixed by the 16-bit address of the instruction set.
  localparam int MemAddrW = 16;
  localparam int MemDepth = 1 << MemAddrW;
  localparam int MemWidth = 8;

  // Request kinds.
  typedef enum logic [1:0] {
    ReqExec   = 2'd0,
    ReqHostWr = 2'd1,
    ReqHostRd = 2'd2,
    ReqNone   = 2'd3
  } req_kind_e;

  // Source addressing modes.
  typedef enum logic [2:0] {
    SrcR8      = 3'd0,
    SrcImm8    = 3'd1,
    SrcImm16   = 3'd2,
    SrcHighC   = 3'd3,
    SrcInd     = 3'd4,
    SrcR16     = 3'd5,
    SrcAbs     = 3'd6,
    SrcInvalid = 3'd7
  } src_mode_e;

  // Destination addressing modes.
  typedef enum logic [2:0] {
    DstR8       = 3'd0,
    DstR16      = 3'd1,
    DstHighC    = 3'd2,
    DstInd      = 3'd3,
    DstHighImm  = 3'd4,
    DstAbs      = 3'd5,
    DstInvalid6 = 3'd6,
    DstInvalid7 = 3'd7
  } dst_mode_e;

  // Completion status codes.
  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBadSrcReg  = 3'd1,
    StBadSrcMode = 3'd2,
    StBadDstReg  = 3'd3,
    StBadDstMode = 3'd4
  } status_e;

  // Post adjustment of HL.
  typedef enum logic [1:0] {
    AdjNone  = 2'd0,
    AdjInc   = 2'd1,
    AdjDec   = 2'd2,
    AdjNone3 = 2'd3
  } adjust_e;

  // Byte register file indexes.
  localparam logic [2:0] IxA = 3'd0;
  localparam logic [2:0] IxB = 3'd1;
  localparam logic [2:0] IxC = 3'd2;
  localparam logic [2:0] IxD = 3'd3;
  localparam logic [2:0] IxE = 3'd4;
  localparam logic [2:0] IxH = 3'd5;
  localparam logic [2:0] IxL = 3'd6;
  localparam logic [2:0] IxF = 3'd7;

  // Register pair codes.
  localparam logic [2:0] PairAf = 3'd0;
  localparam logic [2:0] PairBc = 3'd1;
  localparam logic [2:0] PairDe = 3'd2;
  localparam logic [2:0] PairHl = 3'd3;
  localparam logic [2:0] PairSp = 3'd4;

  // Highest valid byte register and pair codes.
  localparam logic [2:0] MaxR8  = 3'd6;
  localparam logic [2:0] MaxR16 = 3'd4;

  localparam logic [7:0]  FlagH    = 8'h20;
  localparam logic [7:0]  FlagC    = 8'h10;
  localparam logic [15:0] HighPage = 16'hFF00;

  typedef logic [7:0][7:0] byte_regs_t;

  // One request item.
  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] dest_mode;
    logic [2:0] dest_reg;
    logic [2:0] src_mode;
    logic [2:0] src_reg;
    logic [1:0] post_adjust;
    logic       sp_offset_form;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] host_data;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  reg_a;
    logic [7:0]  reg_flags;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [15:0] stack_ptr;
    logic [7:0]  read_data;
  } rsp_t;

  // Execute datapath outputs toward the sequencer.
  typedef struct packed {
    logic [MemAddrW-1:0] rd_addr;
    logic [2:0]          status;
    logic                commit;
    byte_regs_t          regs_n;
    logic [15:0]         sp_n;
    logic                mem_we;
    logic [MemAddrW-1:0] mem_addr;
    logic [7:0]          mem_wdata;
    logic                need_w2;
    logic [MemAddrW-1:0] w2_addr;
    logic [7:0]          w2_data;
    logic [7:0]          read_data;
  } exec_t;

endpackage

// ===== rtl/clu_req_if.sv =====
// Valid/ready channel that carries request items into the unit.
`timescale 1ns / 1ps

interface clu_req_if;
  import clu_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/clu_rsp_if.sv =====
// Valid/ready channel that carries result items out of the unit.
`timescale 1ns / 1ps

interface clu_rsp_if;
  import clu_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/clu_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module clu_ram #(
  parameter int Width = clu_pkg::MemWidth,
  parameter int Depth = clu_pkg::MemDepth
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One access per cycle: a write, or a read whose data appears next cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/clu_exec.sv =====
// Execute datapath: source select, fault checks, register update and store plan.
`timescale 1ns / 1ps

module clu_exec (
  input  clu_pkg::req_t       item_i,
  input  clu_pkg::byte_regs_t regs_i,
  input  logic [15:0]         sp_i,
  input  logic [7:0]          rdata_i,
  output clu_pkg::exec_t      ex_o
);
  import clu_pkg::*;

  logic [15:0] imm16;
  logic [15:0] val;
  logic [15:0] off;
  logic [15:0] hl;
  logic        wide;
  logic        set_flags;
  logic [7:0]  newf;
  logic [4:0]  half_sum;
  logic [8:0]  byte_sum;
  logic [2:0]  st;
  byte_regs_t  regs_n;
  logic [15:0] sp_n;
  logic [MemAddrW-1:0] rd_addr;

  function automatic logic [15:0] pair_of(byte_regs_t r, logic [15:0] sp, logic [2:0] sel);
    logic [15:0] p;
    case (sel)
      PairAf:  p = {r[IxA], r[IxF]};
      PairBc:  p = {r[IxB], r[IxC]};
      PairDe:  p = {r[IxD], r[IxE]};
      PairHl:  p = {r[IxH], r[IxL]};
      default: p = sp;
    endcase
    return p;
  endfunction

  assign imm16    = {item_i.imm_high, item_i.imm_low};
  assign off      = {{8{item_i.imm_low[7]}}, item_i.imm_low};
  assign half_sum = {1'b0, sp_i[3:0]} + {1'b0, item_i.imm_low[3:0]};
  assign byte_sum = {1'b0, sp_i[7:0]} + {1'b0, item_i.imm_low};

  // Address of the memory byte read ahead of execution.
  always_comb begin
    if (item_i.req_type == ReqHostRd) begin
      rd_addr = imm16;
    end else begin
      case (item_i.src_mode)
        SrcHighC: rd_addr = HighPage | {8'h00, regs_i[IxC]};
        SrcInd:   rd_addr = pair_of(regs_i, sp_i, item_i.src_reg);
        default:  rd_addr = imm16;
      endcase
    end
  end

  // Source value and fault checks, sources first.
  always_comb begin
    st        = StOk;
    val       = 16'h0000;
    wide      = 1'b0;
    set_flags = 1'b0;
    newf      = 8'h00;
    case (item_i.src_mode)
      SrcR8: begin
        if (item_i.src_reg > MaxR8) st = StBadSrcReg;
        else val = {8'h00, regs_i[item_i.src_reg]};
      end
      SrcImm8:  val = {8'h00, item_i.imm_low};
      SrcImm16: begin
        val  = imm16;
        wide = 1'b1;
      end
      SrcHighC: val = {8'h00, rdata_i};
      SrcInd: begin
        if (item_i.src_reg > MaxR16) st = StBadSrcReg;
        else val = {8'h00, rdata_i};
      end
      SrcR16: begin
        if (item_i.src_reg > MaxR16) begin
          st = StBadSrcReg;
        end else begin
          val  = pair_of(regs_i, sp_i, item_i.src_reg);
          wide = 1'b1;
          if (item_i.sp_offset_form) begin
            val       = val + off;
            set_flags = 1'b1;
            if (half_sum[4]) newf = newf | FlagH;
            if (byte_sum[8]) newf = newf | FlagC;
          end
        end
      end
      SrcAbs:  val = {8'h00, rdata_i};
      default: st = StBadSrcMode;
    endcase

    if (st == StOk) begin
      case (item_i.dest_mode)
        DstR8:      if (item_i.dest_reg > MaxR8) st = StBadDstReg;
        DstR16:     if (item_i.dest_reg > MaxR16) st = StBadDstReg;
        DstHighC, DstHighImm, DstAbs: st = StOk;
        DstInd: begin
          if (item_i.dest_reg < PairBc || item_i.dest_reg > PairHl) st = StBadDstReg;
        end
        default:    st = StBadDstMode;
      endcase
    end
  end

  // Register updates and the store plan of an accepted load or a host write, and the host read data.
  always_comb begin
    regs_n          = regs_i;
    sp_n            = sp_i;
    ex_o.rd_addr    = rd_addr;
    ex_o.mem_we     = 1'b0;
    ex_o.mem_addr   = imm16;
    ex_o.mem_wdata  = val[7:0];
    ex_o.need_w2    = 1'b0;
    ex_o.w2_addr    = imm16 + 16'd1;
    ex_o.w2_data    = val[15:8];
    ex_o.read_data  = 8'h00;
    ex_o.commit     = 1'b0;
    ex_o.status     = StOk;
    hl              = 16'h0000;

    case (item_i.req_type)
      ReqExec: begin
        ex_o.status = st;
        if (st == StOk) begin
          ex_o.commit = 1'b1;
          if (set_flags) regs_n[IxF] = newf;
          case (item_i.dest_mode)
            DstR8: regs_n[item_i.dest_reg] = val[7:0];
            DstR16: begin
              case (item_i.dest_reg)
                PairAf: {regs_n[IxA], regs_n[IxF]} = val;
                PairBc: {regs_n[IxB], regs_n[IxC]} = val;
                PairDe: {regs_n[IxD], regs_n[IxE]} = val;
                PairHl: {regs_n[IxH], regs_n[IxL]} = val;
                default: sp_n = val;
              endcase
            end
            DstHighC: begin
              ex_o.mem_we   = 1'b1;
              ex_o.mem_addr = HighPage | {8'h00, regs_i[IxC]};
            end
            DstInd: begin
              ex_o.mem_we   = 1'b1;
              ex_o.mem_addr = pair_of(regs_i, sp_i, item_i.dest_reg);
            end
            DstHighImm: begin
              ex_o.mem_we   = 1'b1;
              ex_o.mem_addr = HighPage | {8'h00, item_i.imm_low};
            end
            default: begin
              ex_o.mem_we  = 1'b1;
              ex_o.need_w2 = wide;
            end
          endcase
          // HL adjustment sees the destination write.
          hl = {regs_n[IxH], regs_n[IxL]};
          if (item_i.post_adjust == AdjInc) begin
            {regs_n[IxH], regs_n[IxL]} = hl + 16'd1;
          end else if (item_i.post_adjust == AdjDec) begin
            {regs_n[IxH], regs_n[IxL]} = hl - 16'd1;
          end
        end
      end
      ReqHostWr: begin
        ex_o.mem_we    = 1'b1;
        ex_o.mem_wdata = item_i.host_data;
      end
      ReqHostRd: ex_o.read_data = rdata_i;
      default:   ex_o.status = StOk;
    endcase

    ex_o.regs_n = regs_n;
    ex_o.sp_n   = sp_n;
  end

endmodule

// ===== rtl/cpu_load_instruction_unit.sv =====
// Top level of the load instruction unit: sequencer, register file and main memory.
`timescale 1ns / 1ps

// Usage.
// Requests enter on req_i (valid/ready) and results leave on rsp_o (valid/ready).
// A request executes one decoded byte load, or writes or reads one byte of the
// 64K-byte main memory for a host. Each request gives exactly one result that
// holds the status, all registers after the step and, for a host read, the byte.
// A request reads the single-port memory in SRead, then executes and writes in
// SExec; a 16-bit absolute store writes its high byte in SWrite2. The result is
// valid in the cycle after the last step.
// The single memory port runs one request at a time; the next request is taken
// in the cycle the current one finishes.
// Reset clears the register file and then sweeps all 65536 bytes of the memory
// to zero, one byte a cycle; ready stays low during that sweep.
// A stalled receiver holds the result in the output register; one further
// request runs up to its final step and then waits for the register to free.
module cpu_load_instruction_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  clu_req_if.sink   req_i,
  clu_rsp_if.source rsp_o
);
  import clu_pkg::*;

  typedef enum logic [4:0] {
    SClear  = 5'b00001,
    SIdle   = 5'b00010,
    SRead   = 5'b00100,
    SExec   = 5'b01000,
    SWrite2 = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  req_t                item_q;
  byte_regs_t          regs_q, regs_d;
  logic [15:0]         sp_q, sp_d;
  logic [MemAddrW-1:0] clr_q;
  logic [MemAddrW-1:0] w2_addr_q;
  logic [7:0]          w2_data_q;
  logic                rsp_valid_q;
  rsp_t                rsp_q, rsp_d;
  logic                rsp_load;
  logic                out_free;
  logic                accept;
  logic                done;
  exec_t               ex;

  logic                mem_en;
  logic                mem_we;
  logic [MemAddrW-1:0] mem_addr;
  logic [7:0]          mem_wdata;
  logic [7:0]          mem_rdata;

  function automatic rsp_t pack_rsp(logic [2:0] st, byte_regs_t r, logic [15:0] sp,
                                    logic [7:0] rd);
    rsp_t p;
    p.status    = st;
    p.reg_a     = r[IxA];
    p.reg_flags = r[IxF];
    p.reg_b     = r[IxB];
    p.reg_c     = r[IxC];
    p.reg_d     = r[IxD];
    p.reg_e     = r[IxE];
    p.reg_h     = r[IxH];
    p.reg_l     = r[IxL];
    p.stack_ptr = sp;
    p.read_data = rd;
    return p;
  endfunction

  clu_exec u_exec (
    .item_i  (item_q),
    .regs_i  (regs_q),
    .sp_i    (sp_q),
    .rdata_i (mem_rdata),
    .ex_o    (ex)
  );

  clu_ram #(
    .Width (MemWidth),
    .Depth (MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == SIdle) || done;
  assign accept      = req_i.valid && req_i.ready;

  // Sequencer: the request finishes when its last step can hand over a result.
  always_comb begin
    state_d  = state_q;
    regs_d   = regs_q;
    sp_d     = sp_q;
    done     = 1'b0;
    rsp_load = 1'b0;
    rsp_d    = pack_rsp(ex.status, ex.regs_n, ex.sp_n, ex.read_data);
    case (state_q)
      SClear: begin
        if (clr_q == {MemAddrW{1'b1}}) state_d = SIdle;
      end
      SIdle: begin
        if (accept) state_d = SRead;
      end
      SRead: state_d = SExec;
      SExec: begin
        if (ex.need_w2) begin
          regs_d  = ex.regs_n;
          sp_d    = ex.sp_n;
          state_d = SWrite2;
        end else if (out_free) begin
          if (ex.commit) begin
            regs_d = ex.regs_n;
            sp_d   = ex.sp_n;
          end
          done     = 1'b1;
          rsp_load = 1'b1;
          state_d  = accept ? SRead : SIdle;
        end
      end
      SWrite2: begin
        if (out_free) begin
          done     = 1'b1;
          rsp_load = 1'b1;
          rsp_d    = pack_rsp(StOk, regs_q, sp_q, 8'h00);
          state_d  = accept ? SRead : SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Memory port: clearing sweep, source read, first store, high byte store.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = ex.rd_addr;
    mem_wdata = ex.mem_wdata;
    case (state_q)
      SClear: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = 8'h00;
      end
      SRead: mem_en = 1'b1;
      SExec: begin
        mem_en   = ex.mem_we && (ex.need_w2 || out_free);
        mem_we   = mem_en;
        mem_addr = ex.mem_addr;
      end
      SWrite2: begin
        mem_en    = out_free;
        mem_we    = out_free;
        mem_addr  = w2_addr_q;
        mem_wdata = w2_data_q;
      end
      default: mem_en = 1'b0;
    endcase
  end

  // Control state and register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      regs_q      <= '0;
      sp_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      regs_q  <= regs_d;
      sp_q    <= sp_d;
      if (state_q == SClear) clr_q <= clr_q + 1'b1;
      if (rsp_load) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= req_i.payload;
    if (rsp_load) rsp_q <= rsp_d;
    if (state_q == SExec) begin
      w2_addr_q <= ex.w2_addr;
      w2_data_q <= ex.w2_data;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // No request is taken while the memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SClear) |-> !req_i.ready)
    else $error("request accepted during memory clear");

  // An accepted request always starts with its memory read step.
  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == SRead))
    else $error("accepted request did not enter the read step");

  // The high byte store only follows the execute step.
  a_w2_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWrite2) |-> ($past(state_q) == SExec || $past(state_q) == SWrite2))
    else $error("high byte store without execute step");

  // A result is loaded only when the output register can take it.
  a_rsp_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |-> out_free)
    else $error("result overwrote a pending result");

  // Memory writes happen only in the clear, execute or high byte steps.
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_en && mem_we) |-> (state_q == SClear || state_q == SExec || state_q == SWrite2))
    else $error("memory write outside a store step");

endmodule
